### rtl/core/lapef_pkg.sv
// ----------------------------------------------------------------------------
// lapef_pkg: shared types and constants of the rgb laplacian edge filter
// beat layouts, register map, item codes and queue sizes
// ----------------------------------------------------------------------------
package lapef_pkg;

	// register map
	localparam int FRAME_WIDTH_W  = 12;
	localparam int FRAME_HEIGHT_W = 16;
	localparam int ROW_W          = FRAME_HEIGHT_W + 1;   // rows run up to height+1
	localparam int PADDR_W        = 3;

	localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 12'd640;
	localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd480;

	localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

	// item codes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// queue depths
	localparam int CMD_Q_DEPTH = 4;
	localparam int OUT_DEPTH   = 4;

	typedef struct packed {
		logic       op;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_last;
	} out_beat_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pix_t;

	// classified item handed from front to back
	typedef struct packed {
		pix_t px;        // pixel, already gated to zero outside the pixel rows
		logic c_zero;    // first column of a row
		logic up_ok;     // upper line store holds this frame's data
		logic mid_ok;    // middle line store holds this frame's data
		logic emit;      // item yields a result
		logic last;      // that result closes the frame
		logic restart;   // item ends the frame
	} cmd_t;

endpackage

### rtl/core/lapef_ram.sv
// ----------------------------------------------------------------------------
// lapef_ram: generic single-write, single-read ram
// one write port, one read port with registered data, old data on collision
// ----------------------------------------------------------------------------
module lapef_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/lapef_fifo.sv
// ----------------------------------------------------------------------------
// lapef_fifo: small register fifo
// first-word fall-through, occupancy count for credit logic
// ----------------------------------------------------------------------------
module lapef_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == NW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + NW'(1);
				2'b01:   count_q <= count_q - NW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### rtl/core/lapef_front.sv
// ----------------------------------------------------------------------------
// lapef_front: item intake and classification
// frame position counters, pixel gating and result/last/restart flags
// ----------------------------------------------------------------------------
module lapef_front import lapef_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         restart,
	input  logic [FRAME_WIDTH_W-1:0]     frame_width,
	input  logic [FRAME_HEIGHT_W-1:0]    frame_height,
	input  logic                         push,
	input  in_beat_t                     item,
	output logic                         full,
	input  logic                         q_full,
	output logic                         q_wr,
	output cmd_t                         q_cmd,
	output logic [$clog2(MAX_WIDTH)-1:0] q_col
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int EW   = $clog2(MAX_WIDTH + 1);
	localparam int XW   = EW + 1;
	localparam int CMPW = ((EW > FRAME_WIDTH_W) ? EW : FRAME_WIDTH_W) + 1;
	localparam logic [CMPW-1:0] MAXW_C = CMPW'(MAX_WIDTH);

	logic [CW-1:0]    in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [CW-1:0]    out_col_q;
	logic [ROW_W-1:0] out_row_q;

	logic [CMPW-1:0]  fw_ext;
	logic [EW-1:0]    eff_w;
	logic [ROW_W-1:0] eff_h;
	logic             accept;
	logic [XW-1:0]    in_col_p1;
	logic [XW-1:0]    out_col_p1;
	logic             in_wrap;
	logic             out_wrap;

	// effective frame size: width clamped to 1..MAX_WIDTH, height at least 1
	always_comb begin
		fw_ext = CMPW'(frame_width);
		if (frame_width == '0) begin
			eff_w = EW'(1);
		end else if (fw_ext > MAXW_C) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = EW'(fw_ext);
		end
		eff_h = (frame_height == '0) ? ROW_W'(1) : ROW_W'(frame_height);
	end

	assign accept = push && !q_full;
	assign full   = q_full;
	assign q_wr   = accept;
	assign q_col  = in_col_q;

	always_comb begin
		in_col_p1  = XW'(in_col_q) + XW'(1);
		out_col_p1 = XW'(out_col_q) + XW'(1);
		in_wrap    = (in_col_p1 >= XW'(eff_w));
		out_wrap   = (out_col_p1 >= XW'(eff_w));

		q_cmd.c_zero  = (in_col_q == '0);
		q_cmd.up_ok   = (in_row_q >= ROW_W'(2));
		q_cmd.mid_ok  = (in_row_q != '0);
		q_cmd.emit    = (in_row_q >= ROW_W'(2)) || ((in_row_q == ROW_W'(1)) && !q_cmd.c_zero);
		q_cmd.last    = (out_row_q == eff_h - ROW_W'(1)) &&
		                (XW'(out_col_q) == XW'(eff_w) - XW'(1));
		q_cmd.restart = (in_row_q >= eff_h + ROW_W'(1));
		// drain items in the pixel rows and anything after them count as zero
		if ((item.op == OP_PIXEL) && (in_row_q < eff_h)) begin
			q_cmd.px = '{blue: item.blue_in, green: item.green_in, red: item.red_in};
		end else begin
			q_cmd.px = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (restart || (accept && q_cmd.restart)) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			if (in_wrap) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + ROW_W'(1);
			end else begin
				in_col_q <= CW'(in_col_p1);
			end
			if (q_cmd.emit) begin
				if (out_wrap) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + ROW_W'(1);
				end else begin
					out_col_q <= CW'(out_col_p1);
				end
			end
		end
	end

endmodule

### rtl/core/lapef_back.sv
// ----------------------------------------------------------------------------
// lapef_back: line stores, 3x3 window and laplacian arithmetic
// three stages: store read, window update, response and result fifo
// ----------------------------------------------------------------------------
module lapef_back import lapef_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         restart,
	input  logic                         q_empty,
	input  cmd_t                         q_cmd,
	input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
	output logic                         q_rd,
	output out_beat_t                    result,
	output logic                         empty,
	input  logic                         pop
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int PW  = $bits(pix_t);
	localparam int LW  = 2 * PW;
	localparam int NW  = $clog2(OUT_DEPTH + 1);
	localparam int BW  = $clog2(OUT_DEPTH + 3);
	localparam int OBW = $bits(out_beat_t);

	function automatic logic [7:0] lap_resp(input logic [8:0][7:0] v);
		logic [10:0] nsum;
		logic [12:0] acc;
		nsum = '0;
		for (int k = 0; k < 9; k++) begin
			if (k != 4) begin
				nsum = nsum + 11'(v[k]);
			end
		end
		acc = {2'b00, v[4], 3'b000} - {2'b00, nsum};
		if (acc[12]) begin
			lap_resp = 8'd0;
		end else if (acc[11:8] != '0) begin
			lap_resp = 8'd255;
		end else begin
			lap_resp = acc[7:0];
		end
	endfunction

	// stage 1: line store read in flight
	logic          valid_s1;
	cmd_t          cmd_s1;
	logic [CW-1:0] addr_s1;
	logic          fwd_s1;
	logic [LW-1:0] fwd_data_s1;

	// stage 2: shifted window ready for the arithmetic
	logic          valid_s2;
	pix_t          win_s2 [9];
	logic          last_s2;

	pix_t          win_q [9];

	logic          issue;
	logic [BW-1:0] busy;
	logic [NW-1:0] ofifo_count;
	logic          ofifo_full;
	logic [LW-1:0] ram_rdata;
	logic [LW-1:0] rd_word;
	pix_t          up_px;
	pix_t          mid_raw;
	pix_t          mid_px;
	pix_t          col_new [3];
	pix_t          shifted [9];
	logic [8:0][7:0] red_v;
	logic [8:0][7:0] green_v;
	logic [8:0][7:0] blue_v;
	out_beat_t     resp;
	logic [OBW-1:0] ofifo_rdata;

	// an item enters only when the result fifo has room for everything in flight
	assign busy  = BW'(ofifo_count) + BW'(valid_s1) + BW'(valid_s2);
	assign issue = !q_empty && (busy < BW'(OUT_DEPTH));
	assign q_rd  = issue;

	lapef_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (valid_s1),
		.waddr(addr_s1),
		.wdata({mid_raw, cmd_s1.px}),
		.re   (issue),
		.raddr(q_col),
		.rdata(ram_rdata)
	);

	always_comb begin
		rd_word = fwd_s1 ? fwd_data_s1 : ram_rdata;
		up_px   = cmd_s1.up_ok ? pix_t'(rd_word[LW-1:PW]) : '0;
		mid_raw = pix_t'(rd_word[PW-1:0]);
		mid_px  = cmd_s1.mid_ok ? mid_raw : '0;
		col_new[0] = up_px;
		col_new[1] = mid_px;
		col_new[2] = cmd_s1.px;
		for (int r = 0; r < 3; r++) begin
			shifted[r*3+0] = win_q[r*3+1];
			shifted[r*3+1] = win_q[r*3+2];
			// a row's first column shifts zeros in after the previous row's last pixel
			shifted[r*3+2] = cmd_s1.c_zero ? '0 : col_new[r];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			fwd_s1   <= 1'b0;
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1 && cmd_s1.emit;
			// same address read while being written: take the write data
			fwd_s1   <= issue && valid_s1 && (q_col == addr_s1);
			if (restart || (valid_s1 && cmd_s1.restart)) begin
				for (int k = 0; k < 9; k++) begin
					win_q[k] <= '0;
				end
			end else if (valid_s1 && cmd_s1.c_zero) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r*3+0] <= '0;
					win_q[r*3+1] <= '0;
					win_q[r*3+2] <= col_new[r];
				end
			end else if (valid_s1) begin
				for (int k = 0; k < 9; k++) begin
					win_q[k] <= shifted[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cmd_s1  <= q_cmd;
			addr_s1 <= q_col;
		end
		fwd_data_s1 <= {mid_raw, cmd_s1.px};
		if (valid_s1) begin
			for (int k = 0; k < 9; k++) begin
				win_s2[k] <= shifted[k];
			end
			last_s2 <= cmd_s1.last;
		end
	end

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			red_v[k]   = win_s2[k].red;
			green_v[k] = win_s2[k].green;
			blue_v[k]  = win_s2[k].blue;
		end
		resp.red_out    = lap_resp(red_v);
		resp.green_out  = lap_resp(green_v);
		resp.blue_out   = lap_resp(blue_v);
		resp.frame_last = last_s2;
	end

	lapef_fifo #(
		.WIDTH(OBW),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (valid_s2),
		.wr_data(resp),
		.rd_en  (pop),
		.rd_data(ofifo_rdata),
		.empty  (empty),
		.full   (ofifo_full),
		.count  (ofifo_count)
	);

	assign result = out_beat_t'(ofifo_rdata);

	// credit keeps the fifo from overflowing; full is left unused
	logic unused_full;
	assign unused_full = ofifo_full;

endmodule

### rtl/core/laplacian_edge_filter_rgb.sv
// ----------------------------------------------------------------------------
// laplacian_edge_filter_rgb: streaming 3x3 laplacian edge detector, rgb
// raster pixels in, clamped 8*centre minus neighbours per channel out,
// one row and one pixel behind, last result of the frame flagged
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload       | beat taken when
//  ---------+----------------------+---------------+------------------------------
//  item     | push / full          | in_beat_t     | push high, full low
//  result   | empty / pop          | out_beat_t    | pop high, empty low
//  config   | psel penable pwrite  | paddr, pwdata | psel, penable, pwrite, pready
//
//  one item per clock sustained while results are popped; a result reaches
//  the ports through the queue, line store read, window and arithmetic
//  arst_n clears counters, window and queues; line stores are not cleared,
//  their reads are gated by the row position so no unwritten word is used
//  a 4-entry queue parts intake from the line store pipeline, and a 4-entry
//  result fifo with credit lets either side stall without losing a beat
//  a register write restarts the frame
//
module laplacian_edge_filter_rgb import lapef_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic               clk,
	input  logic               arst_n,
	// item channel
	input  logic               push,
	output logic               full,
	input  in_beat_t           item,
	// result channel
	output logic               empty,
	input  logic               pop,
	output out_beat_t          result,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int QW = CW + $bits(cmd_t);

	logic [FRAME_WIDTH_W-1:0]  frame_width_q;
	logic [FRAME_HEIGHT_W-1:0] frame_height_q;

	logic          cfg_wr;
	logic [0:0]    reg_idx;
	logic          q_full;
	logic          q_wr;
	cmd_t          q_cmd_in;
	logic [CW-1:0] q_col_in;
	logic          q_empty;
	logic          q_rd;
	logic [QW-1:0] q_rdata;
	cmd_t          q_cmd_out;
	logic [CW-1:0] q_col_out;

	// ------------------------------------------------------------------
	// configuration registers, one word each at byte address 4*index
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FRAME_WIDTH_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[FRAME_HEIGHT_W-1:0];
				default:          frame_width_q  <= frame_width_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FRAME_WIDTH:  prdata = 32'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
			default:          prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// front: position counters and classification of each beat
	// ------------------------------------------------------------------
	lapef_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.restart     (cfg_wr),
		.frame_width (frame_width_q),
		.frame_height(frame_height_q),
		.push        (push),
		.item        (item),
		.full        (full),
		.q_full      (q_full),
		.q_wr        (q_wr),
		.q_cmd       (q_cmd_in),
		.q_col       (q_col_in)
	);

	// ------------------------------------------------------------------
	// command queue between front and back
	// ------------------------------------------------------------------
	lapef_fifo #(
		.WIDTH(QW),
		.DEPTH(CMD_Q_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_wr),
		.wr_data({q_col_in, q_cmd_in}),
		.rd_en  (q_rd),
		.rd_data(q_rdata),
		.empty  (q_empty),
		.full   (q_full),
		.count  ()
	);

	assign q_col_out = q_rdata[QW-1:QW-CW];
	assign q_cmd_out = cmd_t'(q_rdata[QW-CW-1:0]);

	// ------------------------------------------------------------------
	// back: line stores, window, arithmetic and result fifo
	// ------------------------------------------------------------------
	lapef_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.restart(cfg_wr),
		.q_empty(q_empty),
		.q_cmd  (q_cmd_out),
		.q_col  (q_col_out),
		.q_rd   (q_rd),
		.result (result),
		.empty  (empty),
		.pop    (pop)
	);

endmodule

### rtl/core/lapef_checker.sv
// ----------------------------------------------------------------------------
// lapef_checker: port-level checks of the rgb laplacian edge filter
// result hold, queue fill behavior and register readback
// ----------------------------------------------------------------------------
module lapef_checker import lapef_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  in_beat_t           item,
	input  logic               empty,
	input  logic               pop,
	input  out_beat_t          result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	input  logic [31:0]        prdata,
	input  logic               pready
);

	// a waiting result beat stays put until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result beat changed while waiting");

	// the intake only fills after an accepted beat
	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without an accepted beat");

	// width register reads back what was written
	a_width_readback: assert property (@(posedge clk) disable iff (!arst_n)
		((psel && penable && pwrite && pready && !paddr[2]) ##1 (psel && !pwrite && !paddr[2]))
		|-> (prdata == 32'($past(pwdata[FRAME_WIDTH_W-1:0]))))
		else $error("frame width readback mismatch");

	// height register reads back what was written
	a_height_readback: assert property (@(posedge clk) disable iff (!arst_n)
		((psel && penable && pwrite && pready && paddr[2]) ##1 (psel && !pwrite && paddr[2]))
		|-> (prdata == 32'($past(pwdata[FRAME_HEIGHT_W-1:0]))))
		else $error("frame height readback mismatch");

	logic unused_item;
	assign unused_item = ^item;

endmodule

bind laplacian_edge_filter_rgb lapef_checker u_lapef_checker (.*);
